/* hw/rtl/pwse_pkg.sv */
// Shared types, constants and functions for the parity word six-of-eight encoder.
// No dependencies; every other file of the block refers to it by scoped names.
`default_nettype none

package pwse_pkg;

	localparam int DATA_W = 24;
	localparam int WORD_W = 30;
	localparam int PAR_W = 6;

	// Word queue between the front and back parts.
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W = 1;
	localparam int QCNT_W = 2;

	localparam logic [2:0] LAST_GROUP = 3'd4;
	localparam logic [7:0] FRAME_MARK = 8'h40;

	typedef logic [WORD_W-1:0] word30_t;

	// Head of the word queue as seen by the back part.
	typedef struct packed {
		logic    valid;
		word30_t word;
	} q_head_t;

	// Parity masks over the 30-bit word, D25 first.
	localparam logic [31:0] PARITY_MASK [PAR_W] = '{
		32'h3b1f3480, 32'h1d8f9a40, 32'h2ec7cd00,
		32'h1763e680, 32'h2bb1f340, 32'h0b7a89c0
	};

	// Set where a parity bit also takes the previous D29, otherwise the previous D30.
	localparam logic [PAR_W-1:0] USES_D29 = 6'b101001;

	// Six parity bits, D25 in bit 5 down to D30 in bit 0.
	function automatic logic [PAR_W-1:0] make_parity(logic [DATA_W-1:0] data,
		logic d29, logic d30);
		logic [WORD_W-1:0] w30;
		logic [PAR_W-1:0] p;
		w30 = {data, 6'b0};
		for (int k = 0; k < PAR_W; k++) begin
			p[PAR_W-1-k] = (^(w30 & PARITY_MASK[k][WORD_W-1:0]))
				^ (USES_D29[PAR_W-1-k] ? d29 : d30);
		end
		return p;
	endfunction

	// One framed byte: the six-bit group, bit-reversed, with the framing bit set.
	function automatic logic [7:0] frame_group(word30_t w, logic [2:0] grp);
		logic [5:0] six;
		logic [5:0] rev;
		case (grp)
			3'd0: six = w[29:24];
			3'd1: six = w[23:18];
			3'd2: six = w[17:12];
			3'd3: six = w[11:6];
			default: six = w[5:0];
		endcase
		for (int k = 0; k < 6; k++) begin
			rev[5-k] = six[k];
		end
		return FRAME_MARK | {2'b00, rev};
	endfunction

endpackage

`default_nettype wire

/* hw/rtl/pwse_if.sv */
// Valid/ready channel interfaces for the input words and the output bytes.
// Depends on pwse_pkg for the data width.
`default_nettype none

interface pwse_in_if;
	logic                        valid;
	logic                        ready;
	logic [pwse_pkg::DATA_W-1:0] data_word;
	logic                        message_start;

	modport source (output valid, output data_word, output message_start, input ready);
	modport sink (input valid, input data_word, input message_start, output ready);
endinterface

interface pwse_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] tx_byte;
	logic       last_of_word;

	modport source (output valid, output tx_byte, output last_of_word, input ready);
	modport sink (input valid, input tx_byte, input last_of_word, output ready);
endinterface

`default_nettype wire

/* hw/rtl/pwse_front.sv */
// Front part: accepts words, inserts the sequence count, computes parity and
// builds the 30-bit transmit word. Depends on pwse_pkg and pwse_if.
`default_nettype none

module pwse_front (
	input  wire logic             clk,
	input  wire logic             arst_n,
	pwse_in_if.sink               in_word,
	input  wire logic             q_full,
	output logic                  push,
	output pwse_pkg::word30_t     push_word
);

	logic       prev_d29_q;
	logic       prev_d30_q;
	logic [2:0] seq_q;
	logic       second_q;

	logic [pwse_pkg::DATA_W-1:0] data;
	logic [pwse_pkg::DATA_W-1:0] sent;
	logic [pwse_pkg::PAR_W-1:0]  par;
	logic                        insert_seq;

	assign in_word.ready = !q_full;
	assign push = in_word.valid && !q_full;

	assign insert_seq = !in_word.message_start && second_q;

	always_comb begin
		data = in_word.data_word;
		if (insert_seq) begin
			data[10:8] = seq_q;
		end
		par = pwse_pkg::make_parity(data, prev_d29_q, prev_d30_q);
		// A set D30 of the previous word inverts the data bits on the line.
		sent = prev_d30_q ? ~data : data;
		push_word = {sent, par};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_d29_q <= 1'b1;
			prev_d30_q <= 1'b1;
			seq_q <= 3'd0;
			second_q <= 1'b0;
		end else if (push) begin
			prev_d29_q <= par[1];
			prev_d30_q <= par[0];
			if (in_word.message_start) begin
				second_q <= 1'b1;
			end else if (second_q) begin
				seq_q <= seq_q + 3'd1;
				second_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/pwse_queue.sv */
// Short word queue between the front and back parts.
// Depends on pwse_pkg for depth and word type.
`default_nettype none

module pwse_queue (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      push,
	input  pwse_pkg::word30_t              push_word,
	input  wire logic                      pop,
	output pwse_pkg::q_head_t              head,
	output logic                           full,
	output logic [pwse_pkg::QCNT_W-1:0]    count
);

	pwse_pkg::word30_t mem [pwse_pkg::QUEUE_DEPTH];

	logic [pwse_pkg::QPTR_W-1:0] wr_ptr_q;
	logic [pwse_pkg::QPTR_W-1:0] rd_ptr_q;
	logic [pwse_pkg::QCNT_W-1:0] count_q;
	logic                        do_pop;

	assign full = (count_q == pwse_pkg::QCNT_W'(pwse_pkg::QUEUE_DEPTH));
	assign count = count_q;
	assign head.valid = (count_q != '0);
	assign head.word = mem[rd_ptr_q];
	assign do_pop = pop && head.valid;

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + pwse_pkg::QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + pwse_pkg::QPTR_W'(1);
			end
			if (push && !do_pop) begin
				count_q <= count_q + pwse_pkg::QCNT_W'(1);
			end else if (!push && do_pop) begin
				count_q <= count_q - pwse_pkg::QCNT_W'(1);
			end
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/pwse_back.sv */
// Back part: splits each queued 30-bit word into five framed bytes and
// holds them in an output register. Depends on pwse_pkg and pwse_if.
`default_nettype none

module pwse_back (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  pwse_pkg::q_head_t head,
	output logic              pop,
	pwse_out_if.source        out_byte
);

	pwse_pkg::word30_t word_q;
	logic [2:0]        grp_q;
	logic              have_q;
	logic              out_valid_q;
	logic [7:0]        out_byte_q;
	logic              out_last_q;
	logic              adv;

	assign out_byte.valid = out_valid_q;
	assign out_byte.tx_byte = out_byte_q;
	assign out_byte.last_of_word = out_last_q;

	assign adv = !out_valid_q || out_byte.ready;
	// The first byte of a word comes straight from the queue head.
	assign pop = adv && !have_q && head.valid;

	always_ff @(posedge clk) begin
		if (adv) begin
			if (have_q) begin
				out_byte_q <= pwse_pkg::frame_group(word_q, grp_q);
				out_last_q <= (grp_q == pwse_pkg::LAST_GROUP);
			end else begin
				out_byte_q <= pwse_pkg::frame_group(head.word, 3'd0);
				out_last_q <= 1'b0;
			end
		end
		if (pop) begin
			word_q <= head.word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grp_q <= 3'd0;
			have_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			if (have_q) begin
				out_valid_q <= 1'b1;
				if (grp_q == pwse_pkg::LAST_GROUP) begin
					have_q <= 1'b0;
				end else begin
					grp_q <= grp_q + 3'd1;
				end
			end else if (head.valid) begin
				out_valid_q <= 1'b1;
				have_q <= 1'b1;
				grp_q <= 3'd1;
			end else begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/parity_word_six_of_eight_encoder_top.sv */
// Parity word six-of-eight encoder: one 24-bit word in, five framed bytes out.
// With an empty queue and a free output register, the first byte of an accepted word
// is written into the queue and then loaded into the output register before it is valid.
// Throughput: the output channel moves one byte a cycle while its ready is held;
// a two-word queue lets the input take new words while bytes are still going out.
// Reset: arst_n empties the queue and clears the output valid flag, sets the stored D29/D30 to one
// and the sequence count and second-word flag to zero.
`default_nettype none

module parity_word_six_of_eight_encoder_top (
	input  wire logic  clk,
	input  wire logic  arst_n,
	pwse_in_if.sink    in_word,
	pwse_out_if.source out_byte
);

	logic                            push;
	pwse_pkg::word30_t               push_word;
	logic                            pop;
	pwse_pkg::q_head_t               head;
	logic                            q_full;
	logic [pwse_pkg::QCNT_W-1:0]     q_count;

	pwse_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_word   (in_word),
		.q_full    (q_full),
		.push      (push),
		.push_word (push_word)
	);

	pwse_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_word (push_word),
		.pop       (pop),
		.head      (head),
		.full      (q_full),
		.count     (q_count)
	);

	pwse_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.pop      (pop),
		.out_byte (out_byte)
	);

	// The queue never holds more words than it has room for.
	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		q_count <= pwse_pkg::QCNT_W'(pwse_pkg::QUEUE_DEPTH))
		else $error("word queue over capacity");

	// A word is only written while the queue has room.
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_full)
		else $error("word written into a full queue");

	// Every byte shown on the output carries the framing pattern in its top bits.
	a_frame_bits: assert property (@(posedge clk) disable iff (!arst_n)
		out_byte.valid |-> (out_byte.tx_byte[7:6] == 2'b01))
		else $error("output byte without framing bits");

	// Words are taken from the queue only while it holds one.
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head.valid)
		else $error("word read from an empty queue");

endmodule

`default_nettype wire
